[design/rlks_pkg.sv]
// Package for the recency list keepalive scheduler.
// Shared widths and the link memory write-enable type; no dependencies.
package rlks_pkg;

   localparam int SLOT_W = 6;   // slot fields on the ports
   localparam int TIME_W = 48;  // tick count
   localparam int WAIT_W = 32;  // wait and staleness limit

   localparam logic [WAIT_W-1:0] STALE_RESET = 32'd1000;

   // field enables of one link memory word
   typedef struct packed {
      logic fresh;   // listed flag and link toward the head
      logic stale;   // link toward the tail
   } link_we_type;

endpackage : rlks_pkg

[design/rlks_link_mem.sv]
// Link memory: per entry {listed, toward_fresher, toward_staler}.
// One write port with field enables, one registered read port. Uses rlks_pkg.
module rlks_link_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int LW    = 7
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [2*LW:0]             rd_data,
   input  rlks_pkg::link_we_type     wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic                      wr_listed,
   input  logic [LW-1:0]             wr_fresher,
   input  logic [LW-1:0]             wr_staler
);
   import rlks_pkg::*;

   logic [2*LW:0] mem [DEPTH];
   logic [2*LW:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en.fresh) begin
         mem[wr_addr][2*LW:LW] <= {wr_listed, wr_fresher};
      end
      if (wr_en.stale) begin
         mem[wr_addr][LW-1:0] <= wr_staler;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : rlks_link_mem

[design/rlks_stamp_mem.sv]
// Timestamp memory: one 48-bit last-activity time per entry.
// Single write port, registered read port. Uses rlks_pkg.
module rlks_stamp_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [rlks_pkg::TIME_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [rlks_pkg::TIME_W-1:0] wr_data
);
   import rlks_pkg::*;

   logic [TIME_W-1:0] mem [DEPTH];
   logic [TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : rlks_stamp_mem

[design/rlks_wait.sv]
// Two-stage time-to-staleness unit: due = stamp + limit, then due - now
// with staleness flag and 32-bit saturation. Uses rlks_pkg.
module rlks_wait (
   input  logic                        clock,
   input  logic [rlks_pkg::TIME_W-1:0] stamp,
   input  logic [rlks_pkg::WAIT_W-1:0] limit,
   input  logic [rlks_pkg::TIME_W-1:0] now,
   output logic [rlks_pkg::WAIT_W-1:0] left,
   output logic                        stale
);
   import rlks_pkg::*;

   logic [TIME_W:0]   due_ff;
   logic [TIME_W:0]   diff;
   logic              stale_in;
   logic              stale_ff;
   logic [WAIT_W-1:0] left_in;
   logic [WAIT_W-1:0] left_ff;

   always_comb begin
      diff     = due_ff - {1'b0, now};
      stale_in = (due_ff <= {1'b0, now});
      if (stale_in) begin
         left_in = '0;
      end else if (|diff[TIME_W:WAIT_W]) begin
         left_in = '1;
      end else begin
         left_in = diff[WAIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      due_ff   <= {1'b0, stamp} + (TIME_W+1)'(limit);
      left_ff  <= left_in;
      stale_ff <= stale_in;
   end

   assign left  = left_ff;
   assign stale = stale_ff;

endmodule : rlks_wait

[design/recency_list_keepalive_scheduler.sv]
// Recency list keepalive scheduler: top level with the operation sequencer.
// Uses rlks_pkg, rlks_link_mem, rlks_stamp_mem and rlks_wait.
//
// Keeps up to SLOTS entries in a doubly linked list from freshest (head) to
// stalest (tail), each with a 48-bit last-activity stamp. Each request word
// is add, remove, freshen or poll and yields exactly one response word.
// Links and listed flags live in a link memory with one write port and
// field enables; stamps live in a second memory. Head and tail are flops.
// After reset the block sweeps the link memory, one entry per cycle,
// clearing the listed flags; req_stall is high meanwhile, while csr writes
// are taken at any time. One word is worked on at a time: an ignored word
// or a poll of an empty list goes straight to the response register. Other
// words are held up by the single write port of the link memory (an
// unlink-and-relink makes up to four writes to it, one per cycle) and the
// two-stage time-left unit, which poll uses once for the stalest entry and
// once more for its fresher neighbour. A finished response sits in the
// output register, so the next request word is accepted while it waits.
// Write stale_limit only while no word is in flight.
module recency_list_keepalive_scheduler #(
   parameter int SLOTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_action,
   input  logic [rlks_pkg::SLOT_W-1:0] req_slot,
   input  logic [rlks_pkg::TIME_W-1:0] req_now,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rlks_pkg::WAIT_W-1:0] rsp_wait_ticks,
   output logic                        rsp_serviced,
   output logic [rlks_pkg::SLOT_W-1:0] rsp_serviced_slot,
   // configuration
   input  logic                        csr_wr_en,
   input  logic [rlks_pkg::WAIT_W-1:0] csr_wr_data
);
   import rlks_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // entry index
   localparam int LW = $clog2(SLOTS + 1);                 // link incl. null
   localparam int CW = ((IW > SLOT_W) ? IW : SLOT_W) + 1; // slot range check
   localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);
   localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);

   typedef enum logic [1:0] {
      ACT_ADD     = 2'd0,
      ACT_REMOVE  = 2'd1,
      ACT_FRESHEN = 2'd2,
      ACT_POLL    = 2'd3
   } action_type;

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b000_0000_0001,  // post-reset sweep of link memory
      S_IDLE   = 11'b000_0000_0010,
      S_LOOK   = 11'b000_0000_0100,  // read data back
      S_DUE    = 11'b000_0000_1000,  // time-left stage 1
      S_LEFT   = 11'b000_0001_0000,  // time-left result
      S_UNL_A  = 11'b000_0010_0000,  // staler link of fresher neighbour
      S_UNL_B  = 11'b000_0100_0000,  // fresher link of staler neighbour
      S_DROP   = 11'b000_1000_0000,  // clear removed entry
      S_PUSH_A = 11'b001_0000_0000,  // entry record and stamp
      S_PUSH_B = 11'b010_0000_0000,  // old head's fresher link, head/tail
      S_DONE   = 11'b100_0000_0000   // hand result to output register
   } state_type;

   // control
   state_type         state_ff, state_in;
   logic [LW-1:0]     head_ff, head_in;
   logic [LW-1:0]     tail_ff, tail_in;
   logic [IW-1:0]     clr_ff, clr_in;
   logic              phase_ff, phase_in;     // 1: looking at tail's neighbour
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WAIT_W-1:0] limit_ff, limit_in;
   // payload
   action_type        act_ff, act_in;
   logic [IW-1:0]     e_ff, e_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [WAIT_W-1:0] res_wait_ff, res_wait_in;
   logic              res_serv_ff, res_serv_in;
   logic [WAIT_W-1:0] rsp_wait_ff, rsp_wait_in;
   logic              rsp_serv_ff, rsp_serv_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // memory ports
   logic              link_re;
   logic [IW-1:0]     link_raddr;
   logic [2*LW:0]     link_rdata;
   link_we_type       link_we;
   logic [IW-1:0]     link_waddr;
   logic              link_wlisted;
   logic [LW-1:0]     link_wfresher;
   logic [LW-1:0]     link_wstaler;
   logic              stamp_re;
   logic [IW-1:0]     stamp_raddr;
   logic [TIME_W-1:0] stamp_rdata;
   logic              stamp_we;

   logic [WAIT_W-1:0] left;
   logic              stale;

   // decoded record of the entry read last
   logic              rec_listed;
   logic [LW-1:0]     rec_f;
   logic [LW-1:0]     rec_s;
   logic [CW-1:0]     slot_wide;
   logic [LW-1:0]     e_link;

   assign rec_listed = link_rdata[2*LW];
   assign rec_f      = link_rdata[2*LW-1:LW];
   assign rec_s      = link_rdata[LW-1:0];
   assign slot_wide  = CW'(req_slot);
   assign e_link     = LW'(e_ff);

   rlks_link_mem #(.DEPTH(SLOTS), .AW(IW), .LW(LW)) u_link_mem (
      .clock      (clock),
      .rd_en      (link_re),
      .rd_addr    (link_raddr),
      .rd_data    (link_rdata),
      .wr_en      (link_we),
      .wr_addr    (link_waddr),
      .wr_listed  (link_wlisted),
      .wr_fresher (link_wfresher),
      .wr_staler  (link_wstaler)
   );

   rlks_stamp_mem #(.DEPTH(SLOTS), .AW(IW)) u_stamp_mem (
      .clock   (clock),
      .rd_en   (stamp_re),
      .rd_addr (stamp_raddr),
      .rd_data (stamp_rdata),
      .wr_en   (stamp_we),
      .wr_addr (e_ff),
      .wr_data (now_ff)
   );

   rlks_wait u_wait (
      .clock (clock),
      .stamp (stamp_rdata),
      .limit (limit_ff),
      .now   (now_ff),
      .left  (left),
      .stale (stale)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      clr_in        = clr_ff;
      phase_in      = phase_ff;
      act_in        = act_ff;
      e_in          = e_ff;
      now_in        = now_ff;
      res_wait_in   = res_wait_ff;
      res_serv_in   = res_serv_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_serv_in   = rsp_serv_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;

      link_re       = 1'b0;
      link_raddr    = e_ff;
      link_we       = '0;
      link_waddr    = e_ff;
      link_wlisted  = 1'b0;
      link_wfresher = NULL_LINK;
      link_wstaler  = NULL_LINK;
      stamp_re      = 1'b0;
      stamp_raddr   = e_ff;
      stamp_we      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            link_we    = '{fresh: 1'b1, stale: 1'b1};
            link_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               act_in      = action_type'(req_action);
               now_in      = req_now;
               phase_in    = 1'b0;
               res_wait_in = '0;
               res_serv_in = 1'b0;
               if (action_type'(req_action) == ACT_POLL) begin
                  if (tail_ff == NULL_LINK) begin
                     res_wait_in = limit_ff;
                     state_in    = S_DONE;
                  end else begin
                     e_in     = tail_ff[IW-1:0];
                     state_in = S_LOOK;
                  end
               end else if (slot_wide < CW'(SLOTS)) begin
                  e_in     = slot_wide[IW-1:0];
                  state_in = S_LOOK;
               end else begin
                  state_in = S_DONE;   // out-of-range slot: ignored
               end
               link_re     = 1'b1;
               link_raddr  = e_in;
               stamp_re    = 1'b1;
               stamp_raddr = e_in;
            end
         end

         S_LOOK: begin
            priority if (act_ff == ACT_POLL) begin
               state_in = S_DUE;
            end else if (act_ff == ACT_REMOVE) begin
               state_in = rec_listed ? S_UNL_A : S_DONE;
            end else if (rec_listed && head_ff == e_link) begin
               stamp_we = 1'b1;   // already freshest: restamp only
               state_in = S_DONE;
            end else if (rec_listed) begin
               state_in = S_UNL_A;
            end else begin
               state_in = S_PUSH_A;
            end
         end

         S_DUE: begin
            state_in = S_LEFT;
         end

         S_LEFT: begin
            if (phase_ff) begin
               res_wait_in = left;
               state_in    = S_UNL_A;
            end else if (!stale) begin
               res_wait_in = left;
               state_in    = S_DONE;
            end else begin
               res_serv_in = 1'b1;
               if (rec_f == NULL_LINK) begin
                  // lone entry: it is also the head, restamp only
                  res_wait_in = limit_ff;
                  stamp_we    = 1'b1;
                  state_in    = S_DONE;
               end else begin
                  stamp_re    = 1'b1;
                  stamp_raddr = rec_f[IW-1:0];
                  phase_in    = 1'b1;
                  state_in    = S_LOOK;
               end
            end
         end

         S_UNL_A: begin
            if (tail_ff == e_link) begin
               tail_in = rec_f;
            end
            if (head_ff == e_link) begin
               head_in = rec_s;
            end
            if (rec_f != NULL_LINK) begin
               link_we.stale = 1'b1;
               link_waddr    = rec_f[IW-1:0];
               link_wstaler  = rec_s;
            end
            state_in = S_UNL_B;
         end

         S_UNL_B: begin
            if (rec_s != NULL_LINK) begin
               link_we.fresh = 1'b1;
               link_waddr    = rec_s[IW-1:0];
               link_wlisted  = 1'b1;
               link_wfresher = rec_f;
            end
            state_in = (act_ff == ACT_REMOVE) ? S_DROP : S_PUSH_A;
         end

         S_DROP: begin
            link_we  = '{fresh: 1'b1, stale: 1'b1};
            state_in = S_DONE;
         end

         S_PUSH_A: begin
            link_we      = '{fresh: 1'b1, stale: 1'b1};
            link_wlisted = 1'b1;
            link_wstaler = head_ff;
            stamp_we     = 1'b1;
            state_in     = S_PUSH_B;
         end

         S_PUSH_B: begin
            if (head_ff != NULL_LINK) begin
               link_we.fresh = 1'b1;
               link_waddr    = head_ff[IW-1:0];
               link_wlisted  = 1'b1;
               link_wfresher = e_link;
            end
            head_in = e_link;
            if (tail_ff == NULL_LINK) begin
               tail_in = e_link;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_wait_in  = res_wait_ff;
               rsp_serv_in  = res_serv_ff;
               rsp_slot_in  = res_serv_ff ? SLOT_W'(e_ff) : '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         head_ff      <= NULL_LINK;
         tail_ff      <= NULL_LINK;
         clr_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= STALE_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         clr_ff       <= clr_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      e_ff        <= e_in;
      now_ff      <= now_in;
      res_wait_ff <= res_wait_in;
      res_serv_ff <= res_serv_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_serv_ff <= rsp_serv_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wait_ticks    = rsp_wait_ff;
   assign rsp_serviced      = rsp_serv_ff;
   assign rsp_serviced_slot = rsp_slot_ff;

`ifndef SYNTHESIS
   // head and tail are null together: the list is empty or it is not
   a_ends_agree: assert property (@(posedge clock) disable iff (reset)
      (head_ff == NULL_LINK) == (tail_ff == NULL_LINK))
      else $error("head and tail disagree on empty list");

   // no memory write while a word can be accepted (reads issue there)
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!link_we.fresh && !link_we.stale && !stamp_we))
      else $error("memory write in idle");

   // a read never meets a write in the same cycle
   a_rd_wr_apart: assert property (@(posedge clock) disable iff (reset)
      (link_re || stamp_re) |-> (!link_we.fresh && !link_we.stale && !stamp_we))
      else $error("memory read overlaps write");

   // one word at a time: an accept closes the request side next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word accepted while busy");

   // serviced slot is zero unless an entry was serviced
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_serviced) |-> (rsp_serviced_slot == '0))
      else $error("serviced slot set without service");
`endif

endmodule : recency_list_keepalive_scheduler

[tb/rlks_tb_pkg.sv]
// Testbench package for the recency list keepalive scheduler.
// Holds the request action codes shared by the checker and the testbench top.
package rlks_tb_pkg;

   typedef enum logic [1:0] {
      ACT_ADD     = 2'd0,
      ACT_REMOVE  = 2'd1,
      ACT_FRESHEN = 2'd2,
      ACT_POLL    = 2'd3
   } keepalive_action_type;

endpackage : rlks_tb_pkg

[tb/recency_list_keepalive_scheduler_checker.sv]
// Checker for the recency list keepalive scheduler: watches both channels and the csr port,
// predicts each response word from its own copy of the recency list, compares in order.
// Depends on rlks_pkg and rlks_tb_pkg.
module recency_list_keepalive_scheduler_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_action,
   input  logic [rlks_pkg::SLOT_W-1:0] req_slot,
   input  logic [rlks_pkg::TIME_W-1:0] req_now,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [rlks_pkg::WAIT_W-1:0] rsp_wait_ticks,
   input  logic                        rsp_serviced,
   input  logic [rlks_pkg::SLOT_W-1:0] rsp_serviced_slot,
   input  logic                        csr_wr_en,
   input  logic [rlks_pkg::WAIT_W-1:0] csr_wr_data,
   output int                          fail_count,
   output int                          words_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   import rlks_pkg::*;
   import rlks_tb_pkg::*;

   localparam int         NSLOT   = 64;
   localparam logic [6:0] NO_SLOT = 7'd64;

   typedef struct packed {
      logic [WAIT_W-1:0] wait_ticks;
      logic              serviced;
      logic [SLOT_W-1:0] serviced_slot;
   } keepalive_rsp_type;

   logic [TIME_W-1:0] last_seen [NSLOT];
   logic [6:0]        up_link   [NSLOT];   // towards the freshest end
   logic [6:0]        down_link [NSLOT];   // towards the stalest end
   logic              on_list   [NSLOT];
   logic [6:0]        freshest;
   logic [6:0]        stalest;
   logic [WAIT_W-1:0] limit_ticks;

   keepalive_rsp_type pending_rsp_q [$];
   keepalive_rsp_type want;

   function automatic void clear_list();
      for (int i = 0; i < NSLOT; i++) begin
         last_seen[i] = '0;
         up_link[i]   = NO_SLOT;
         down_link[i] = NO_SLOT;
         on_list[i]   = 1'b0;
      end
      freshest = NO_SLOT;
      stalest  = NO_SLOT;
   endfunction

   // time until entry e goes stale, saturated to 32 bits; no wrap on the sum
   function automatic logic [WAIT_W-1:0] ticks_to_stale(logic [5:0] e, logic [TIME_W-1:0] t);
      logic [63:0] due;
      due = 64'(last_seen[e]) + 64'(limit_ticks);
      if (due <= 64'(t))
         return '0;
      if (due - 64'(t) > 64'hFFFF_FFFF)
         return '1;
      return WAIT_W'(due - 64'(t));
   endfunction

   function automatic void unlink_slot(logic [5:0] e);
      logic [6:0] up;
      logic [6:0] down;
      up   = up_link[e];
      down = down_link[e];
      if (freshest == {1'b0, e})
         freshest = down;
      if (stalest == {1'b0, e})
         stalest = up;
      if (up != NO_SLOT)
         down_link[up[5:0]] = down;
      if (down != NO_SLOT)
         up_link[down[5:0]] = up;
      up_link[e]   = NO_SLOT;
      down_link[e] = NO_SLOT;
      on_list[e]   = 1'b0;
   endfunction

   function automatic void freshen_slot(logic [5:0] e, logic [TIME_W-1:0] t);
      if (on_list[e] && freshest == {1'b0, e}) begin
         last_seen[e] = t;
         return;
      end
      if (on_list[e])
         unlink_slot(e);
      last_seen[e] = t;
      up_link[e]   = NO_SLOT;
      down_link[e] = freshest;
      if (freshest != NO_SLOT)
         up_link[freshest[5:0]] = {1'b0, e};
      freshest = {1'b0, e};
      if (stalest == NO_SLOT)
         stalest = {1'b0, e};
      on_list[e] = 1'b1;
   endfunction

   function automatic keepalive_rsp_type predict_rsp(keepalive_action_type act, logic [5:0] s,
                                                     logic [TIME_W-1:0] t);
      keepalive_rsp_type r;
      logic [5:0]        old;
      r = '0;
      unique case (act)
         ACT_POLL: begin
            if (stalest == NO_SLOT) begin
               r.wait_ticks = limit_ticks;
            end else begin
               old = stalest[5:0];
               if (64'(last_seen[old]) + 64'(limit_ticks) > 64'(t)) begin
                  r.wait_ticks = ticks_to_stale(old, t);
               end else begin
                  // wait comes from the next entry, taken before the relink
                  if (up_link[old] != NO_SLOT)
                     r.wait_ticks = ticks_to_stale(up_link[old][5:0], t);
                  else
                     r.wait_ticks = limit_ticks;
                  freshen_slot(old, t);
                  r.serviced      = 1'b1;
                  r.serviced_slot = old;
               end
            end
         end
         ACT_REMOVE: begin
            if (on_list[s])
               unlink_slot(s);
         end
         default: begin
            freshen_slot(s, t);   // add and freshen behave alike
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_list();
         limit_ticks = STALE_RESET;
         pending_rsp_q.delete();
      end else begin
         if (csr_wr_en)
            limit_ticks = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp_q.size() == 0) begin
               $display("%0t ns: response word with none expected: wait %0d serviced %0d slot %0d",
                        $time, rsp_wait_ticks, rsp_serviced, rsp_serviced_slot);
               fail_count++;
            end else begin
               want = pending_rsp_q.pop_front();
               if (rsp_wait_ticks !== want.wait_ticks) begin
                  $display("%0t ns: wait_ticks expected %0d actual %0d",
                           $time, want.wait_ticks, rsp_wait_ticks);
                  fail_count++;
               end
               if (rsp_serviced !== want.serviced) begin
                  $display("%0t ns: serviced expected %0d actual %0d",
                           $time, want.serviced, rsp_serviced);
                  fail_count++;
               end
               if (rsp_serviced_slot !== want.serviced_slot) begin
                  $display("%0t ns: serviced_slot expected %0d actual %0d",
                           $time, want.serviced_slot, rsp_serviced_slot);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_rsp_q.push_back(predict_rsp(keepalive_action_type'(req_action), req_slot,
                                                req_now));
      end
      words_in_flight <= pending_rsp_q.size();
   end

endmodule : recency_list_keepalive_scheduler_checker

[tb/recency_list_keepalive_scheduler_tb.sv]
// Testbench top for the recency list keepalive scheduler: clock, reset, request words,
// response stalls and csr writes; the verdict comes from the checker's failure count.
// Depends on rlks_pkg, rlks_tb_pkg, the checker module and the scheduler RTL.
module recency_list_keepalive_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rlks_pkg::*;
   import rlks_tb_pkg::*;

   // every input known from time zero
   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic [1:0]        req_action        = ACT_ADD;
   logic [SLOT_W-1:0] req_slot          = '0;
   logic [TIME_W-1:0] req_now           = '0;
   logic              rsp_stall         = 1'b0;
   logic              csr_wr_en         = 1'b0;
   logic [WAIT_W-1:0] csr_wr_data       = '0;
   logic              req_stall;
   logic              rsp_valid;
   logic [WAIT_W-1:0] rsp_wait_ticks;
   logic              rsp_serviced;
   logic [SLOT_W-1:0] rsp_serviced_slot;

   int                fail_count;
   int                words_in_flight;

   // idling odds, per cycle, in percent
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;

   // stimulus working variables
   logic [WAIT_W-1:0]    cur_limit = STALE_RESET;
   logic [TIME_W-1:0]    tick_clock;
   logic [63:0]          step;
   logic [5:0]           slot_top;
   keepalive_action_type act;
   int                   r;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   recency_list_keepalive_scheduler u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_slot          (req_slot),
      .req_now           (req_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_wait_ticks    (rsp_wait_ticks),
      .rsp_serviced      (rsp_serviced),
      .rsp_serviced_slot (rsp_serviced_slot),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   recency_list_keepalive_scheduler_checker u_chk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_slot          (req_slot),
      .req_now           (req_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_wait_ticks    (rsp_wait_ticks),
      .rsp_serviced      (rsp_serviced),
      .rsp_serviced_slot (rsp_serviced_slot),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fail_count        (fail_count),
      .words_in_flight   (words_in_flight)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Offer one request word and hold it until the edge that takes it.
   // Idle cycles go in front of the word, never while it is stalled.
   task automatic send_word(input keepalive_action_type a, input logic [SLOT_W-1:0] s,
                            input logic [TIME_W-1:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= a;
      req_slot   <= s;
      req_now    <= t;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait for every outstanding response word.
   // The first edge lets the checker's count catch up with the last accept.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0)
         @(posedge clock);
   endtask

   // Staleness limit may only change with nothing in flight, so the write
   // waits until every response word has come back.
   task automatic write_limit(input logic [WAIT_W-1:0] v);
      wait_drained();
      repeat (12) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_limit = v;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // -------- directed words, limit 100 --------
      // the block sweeps its link memory after reset; req_stall holds us off
      write_limit(32'd100);
      send_word(ACT_POLL,    6'd0,  48'd10);    // poll with nothing listed
      send_word(ACT_ADD,     6'd0,  48'd0);
      send_word(ACT_POLL,    6'd63, 48'd50);    // stalest not yet stale
      send_word(ACT_ADD,     6'd63, 48'd10);
      send_word(ACT_ADD,     6'd0,  48'd20);    // add of a listed entry
      send_word(ACT_FRESHEN, 6'd5,  48'd30);    // freshen of an unlisted entry
      send_word(ACT_REMOVE,  6'd7,  48'd30);    // remove of an unlisted entry
      send_word(ACT_POLL,    6'd0,  48'd115);   // services 63, next not yet stale
      send_word(ACT_REMOVE,  6'd5,  48'd116);   // unlink from the middle
      send_word(ACT_FRESHEN, 6'd63, 48'd120);   // freshen of the head
      send_word(ACT_POLL,    6'd0,  48'd300);   // services, next already stale
      send_word(ACT_POLL,    6'd0,  48'd300);   // services, next fresh
      send_word(ACT_REMOVE,  6'd63, 48'd300);   // unlink the head
      send_word(ACT_REMOVE,  6'd0,  48'd300);   // list empty again
      send_word(ACT_ADD,     6'd42, 48'hFFFF_FFFF_FFFF);
      send_word(ACT_POLL,    6'd0,  48'd0);     // time gone backwards: wait saturates
      send_word(ACT_POLL,    6'd0,  48'hFFFF_FFFF_FFFF);
      send_word(ACT_ADD,     6'd21, 48'hFFFF_FFFF_FFFF);
      send_word(ACT_REMOVE,  6'd42, 48'hFFFF_FFFF_FFFF);  // unlink the tail
      send_word(ACT_POLL,    6'd0,  48'h8000_0000_0000);
      send_word(ACT_REMOVE,  6'd21, 48'h8000_0000_0000);
      send_word(ACT_ADD,     6'd1,  48'h5555_5555_5555);
      send_word(ACT_POLL,    6'd0,  48'hAAAA_AAAA_AAAA);  // services the only entry
      send_word(ACT_REMOVE,  6'd1,  48'hAAAA_AAAA_AAAA);

      // -------- random words --------
      // Six segments of 75 words, each with its own limit. Idling: sender light and
      // receiver heavy, then the reverse, then none. Odd segments crowd onto eight
      // slots so the list empties and refills; even ones use all 64.
      tick_clock = '0;
      for (int seg = 0; seg < 6; seg++) begin
         unique case (seg)
            0:       write_limit(32'd0);
            1:       write_limit(32'hFFFF_FFFF);
            2:       write_limit(STALE_RESET);
            3:       write_limit(32'd37);
            4:       write_limit(32'd250000);
            default: write_limit(WAIT_W'($urandom_range(1, 5000)));
         endcase
         unique case (seg / 2)
            0: begin
               send_idle_pct  = 7;
               recv_stall_pct = 79;
            end
            1: begin
               send_idle_pct  = 79;
               recv_stall_pct = 7;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         slot_top = seg[0] ? 6'd7 : 6'd63;
         for (int n = 0; n < 75; n++) begin
            // now and then hold off until the block has answered everything
            if ($urandom_range(49) == 0)
               wait_drained();
            // time mostly creeps forward by a fraction of the limit, sometimes
            // jumps past it, sometimes steps back or lands anywhere
            step = 64'(cur_limit) / 4 + 2;
            r = $urandom_range(99);
            if (r < 70)
               tick_clock = tick_clock + TIME_W'($urandom_range(0, step[31:0]));
            else if (r < 90)
               tick_clock = tick_clock + TIME_W'(cur_limit)
                            + TIME_W'($urandom_range(0, step[31:0]));
            else if (r < 95)
               tick_clock = tick_clock - TIME_W'($urandom_range(0, step[31:0]));
            else
               tick_clock = TIME_W'({$urandom, $urandom});
            r = $urandom_range(99);
            act = (r < 30) ? ACT_ADD : (r < 45) ? ACT_REMOVE :
                  (r < 65) ? ACT_FRESHEN : ACT_POLL;
            send_word(act, SLOT_W'($urandom_range(0, slot_top)), tick_clock);
         end
      end

      // drain, then give a stray word time to show up
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && words_in_flight == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule : recency_list_keepalive_scheduler_tb
